// ----- sv/zz_pkg.sv -----
// Shared constants, state encoding and inter-module structs for the zigzag
// permutation counter. No dependencies.

package zz_pkg;

    localparam int MAX_LENGTH = 128;
    localparam int LEN_W      = 8;
    localparam int CNT_W      = 20;
    localparam int ADDR_W     = $clog2(MAX_LENGTH);
    localparam int NUM_W      = $clog2(MAX_LENGTH + 1);
    localparam int CMP_W      = (NUM_W > LEN_W) ? NUM_W : LEN_W;

    localparam logic [CNT_W-1:0] ZZ_MOD = CNT_W'(1000000);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_ROW,
        ST_DRAIN,
        ST_SUM,
        ST_SUM_DRAIN,
        ST_DOUBLE,
        ST_FINISH
    } zz_state_t;

    // row store access for one cycle
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CNT_W-1:0]  wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } zz_ram_req_t;

    // finished answer offered to the output register
    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] value;
    } zz_res_t;

endpackage

// ----- sv/zz_if.sv -----
// Valid/ready channel interfaces for the length request and the count result.
// Depends on zz_pkg.

interface zz_len_if;
    logic                       valid;
    logic                       ready;
    logic [zz_pkg::LEN_W-1:0]   length;

    modport source (output valid, output length, input ready);
    modport sink   (input valid, input length, output ready);
endinterface

interface zz_count_if;
    logic                       valid;
    logic                       ready;
    logic [zz_pkg::CNT_W-1:0]   count;

    modport source (output valid, output count, input ready);
    modport sink   (input valid, input count, output ready);
endinterface

// ----- sv/zz_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module zz_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- sv/zz_modadd.sv -----
// Shared adder: sum of two residues reduced by one conditional subtract.
// Depends on zz_pkg.

module zz_modadd (
    input  logic [zz_pkg::CNT_W-1:0] a,
    input  logic [zz_pkg::CNT_W-1:0] b,
    output logic [zz_pkg::CNT_W-1:0] sum
);

    logic [zz_pkg::CNT_W:0] raw;

    always_comb
    begin
        raw = {1'b0, a} + {1'b0, b};
        if (raw >= {1'b0, zz_pkg::ZZ_MOD})
        begin
            sum = zz_pkg::CNT_W'(raw - {1'b0, zz_pkg::ZZ_MOD});
        end
        else
        begin
            sum = zz_pkg::CNT_W'(raw);
        end
    end

endmodule

// ----- sv/zz_seq.sv -----
// Sequencer for the boustrophedon table: streams each row through the row
// store and the shared adder, then sums the last row and doubles it.
// Depends on zz_pkg.

module zz_seq (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    input  logic [zz_pkg::LEN_W-1:0]   req_length,
    output logic                       req_ready,
    output zz_pkg::zz_res_t            res,
    input  logic                       res_take,
    output zz_pkg::zz_ram_req_t        ram_req,
    input  logic [zz_pkg::CNT_W-1:0]   ram_rdata,
    output logic [zz_pkg::CNT_W-1:0]   add_a,
    output logic [zz_pkg::CNT_W-1:0]   add_b,
    input  logic [zz_pkg::CNT_W-1:0]   add_sum
);

    zz_pkg::zz_state_t state_reg, state_next;

    logic [zz_pkg::NUM_W-1:0]  n_reg, n_next;
    logic [zz_pkg::ADDR_W-1:0] k_reg, k_next;
    logic [zz_pkg::ADDR_W-1:0] i_reg, i_next;
    logic [zz_pkg::CNT_W-1:0]  carry_reg, carry_next;
    logic [zz_pkg::CNT_W-1:0]  result_reg, result_next;
    logic                      p_valid_reg, p_valid_next;
    logic [zz_pkg::ADDR_W-1:0] p_addr_reg, p_addr_next;
    logic                      p_zero_reg, p_zero_next;

    logic [zz_pkg::CMP_W-1:0]  len_ext;
    logic [zz_pkg::NUM_W-1:0]  len_sat;
    logic [zz_pkg::NUM_W-1:0]  nm1;
    logic [zz_pkg::ADDR_W-1:0] last_row;
    logic [zz_pkg::ADDR_W-1:0] last_sum;
    logic [zz_pkg::ADDR_W-1:0] issue_addr;
    logic                      issue_zero;
    logic                      odd_row;
    logic                      row_done;

    // request decode and loop bounds
    always_comb
    begin
        len_ext = zz_pkg::CMP_W'(req_length);
        if (len_ext > zz_pkg::CMP_W'(zz_pkg::MAX_LENGTH))
        begin
            len_sat = zz_pkg::NUM_W'(zz_pkg::MAX_LENGTH);
        end
        else
        begin
            len_sat = zz_pkg::NUM_W'(len_ext);
        end

        nm1      = n_reg - zz_pkg::NUM_W'(1);
        odd_row  = k_reg[0];
        row_done = (k_reg == zz_pkg::ADDR_W'(nm1));
        // odd rows run k entries backwards, even rows k+1 entries forwards
        last_row = odd_row ? (k_reg - zz_pkg::ADDR_W'(1)) : k_reg;
        // last row holds n-1 entries when n-1 is odd, n otherwise
        last_sum = nm1[0] ? zz_pkg::ADDR_W'(nm1 - zz_pkg::NUM_W'(1))
                          : zz_pkg::ADDR_W'(nm1);

        if (state_reg == zz_pkg::ST_ROW && odd_row)
        begin
            issue_addr = k_reg - zz_pkg::ADDR_W'(1) - i_reg;
            issue_zero = 1'b0;
        end
        else if (state_reg == zz_pkg::ST_ROW)
        begin
            issue_addr = i_reg;
            // entries k-1 and k of an even row take nothing from the old row
            issue_zero = (i_reg >= k_reg - zz_pkg::ADDR_W'(1));
        end
        else
        begin
            issue_addr = i_reg;
            issue_zero = 1'b0;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            zz_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (len_sat < zz_pkg::NUM_W'(2))
                    begin
                        state_next = zz_pkg::ST_FINISH;
                    end
                    else
                    begin
                        state_next = zz_pkg::ST_INIT;
                    end
                end
            end
            zz_pkg::ST_INIT:
            begin
                state_next = zz_pkg::ST_ROW;
            end
            zz_pkg::ST_ROW:
            begin
                if (i_reg == last_row)
                begin
                    state_next = zz_pkg::ST_DRAIN;
                end
            end
            zz_pkg::ST_DRAIN:
            begin
                state_next = row_done ? zz_pkg::ST_SUM : zz_pkg::ST_ROW;
            end
            zz_pkg::ST_SUM:
            begin
                if (i_reg == last_sum)
                begin
                    state_next = zz_pkg::ST_SUM_DRAIN;
                end
            end
            zz_pkg::ST_SUM_DRAIN:
            begin
                state_next = zz_pkg::ST_DOUBLE;
            end
            zz_pkg::ST_DOUBLE:
            begin
                state_next = zz_pkg::ST_FINISH;
            end
            zz_pkg::ST_FINISH:
            begin
                if (res_take)
                begin
                    state_next = zz_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = zz_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs: handshake, row store port and adder operands
    always_comb
    begin
        req_ready  = (state_reg == zz_pkg::ST_IDLE);
        res.done   = (state_reg == zz_pkg::ST_FINISH);
        res.value  = result_reg;

        ram_req    = '0;
        add_a      = carry_reg;
        add_b      = p_zero_reg ? '0 : ram_rdata;

        case (state_reg)
            zz_pkg::ST_INIT:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = '0;
                ram_req.wdata = zz_pkg::CNT_W'(1);
            end
            zz_pkg::ST_ROW, zz_pkg::ST_DRAIN:
            begin
                ram_req.re    = (state_reg == zz_pkg::ST_ROW);
                ram_req.raddr = issue_addr;
                ram_req.we    = p_valid_reg;
                ram_req.waddr = p_addr_reg;
                // odd rows store the running sum, even rows the sum so far
                ram_req.wdata = odd_row ? add_sum : carry_reg;
            end
            zz_pkg::ST_SUM:
            begin
                ram_req.re    = 1'b1;
                ram_req.raddr = issue_addr;
            end
            zz_pkg::ST_DOUBLE:
            begin
                add_b = carry_reg;
            end
            default:
            begin
                ram_req = '0;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        n_next       = n_reg;
        k_next       = k_reg;
        i_next       = i_reg;
        carry_next   = carry_reg;
        result_next  = result_reg;
        p_valid_next = 1'b0;
        p_addr_next  = issue_addr;
        p_zero_next  = issue_zero;

        if (state_reg == zz_pkg::ST_ROW || state_reg == zz_pkg::ST_SUM)
        begin
            p_valid_next = 1'b1;
            i_next       = i_reg + zz_pkg::ADDR_W'(1);
        end

        if (p_valid_reg)
        begin
            carry_next = add_sum;
        end

        case (state_reg)
            zz_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    n_next      = len_sat;
                    carry_next  = '0;
                    result_next = (len_sat == zz_pkg::NUM_W'(1)) ? zz_pkg::CNT_W'(1) : '0;
                end
            end
            zz_pkg::ST_INIT:
            begin
                k_next     = zz_pkg::ADDR_W'(1);
                i_next     = '0;
                carry_next = '0;
            end
            zz_pkg::ST_DRAIN:
            begin
                i_next     = '0;
                carry_next = '0;
                if (!row_done)
                begin
                    k_next = k_reg + zz_pkg::ADDR_W'(1);
                end
            end
            zz_pkg::ST_DOUBLE:
            begin
                result_next = add_sum;
            end
            default:
            begin
                result_next = result_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= zz_pkg::ST_IDLE;
            p_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            p_valid_reg <= p_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        k_reg      <= k_next;
        i_reg      <= i_next;
        carry_reg  <= carry_next;
        result_reg <= result_next;
        p_addr_reg <= p_addr_next;
        p_zero_reg <= p_zero_next;
    end

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == zz_pkg::ST_ROW) |-> (zz_pkg::NUM_W'(k_reg) < n_reg))
        else $error("row index beyond length");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_req.we |-> (zz_pkg::NUM_W'(ram_req.waddr) < n_reg))
        else $error("row store write beyond current length");

    a_no_same_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_req.we && ram_req.re) |-> (ram_req.waddr != ram_req.raddr))
        else $error("read and write of the same entry in one cycle");

    a_carry_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != zz_pkg::ST_IDLE) |-> (carry_reg < zz_pkg::ZZ_MOD))
        else $error("running sum not reduced");

endmodule

// ----- sv/zig_zag_top_placeholder_removed.sv -----
// Helper: registered output stage holding one finished count.
// Depends on zz_pkg and zz_if.

module zz_outreg (
    input  logic                clk,
    input  logic                rst_n,
    input  zz_pkg::zz_res_t     res,
    output logic                res_take,
    zz_count_if.source          result
);

    logic                     valid_reg, valid_next;
    logic [zz_pkg::CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        res_take   = res.done && (!valid_reg || result.ready);
        valid_next = valid_reg;
        count_next = count_reg;
        if (res_take)
        begin
            valid_next = 1'b1;
            count_next = res.value;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg <= count_next;
    end

    assign result.valid = valid_reg;
    assign result.count = count_reg;

    a_count_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (count_reg < zz_pkg::ZZ_MOD))
        else $error("count offered without reduction");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !result.ready) |-> !res_take)
        else $error("pending count overwritten");

    a_take_loads: assert property (@(posedge clk) disable iff (!rst_n)
        res_take |=> (valid_reg && count_reg == $past(res.value)))
        else $error("finished count not loaded");

endmodule

// ----- sv/zigzag_permutation_counter.sv -----
// Sequence: lengths 0 and 1 go from idle straight to the finish state; otherwise
// the sequencer makes one row-store access and one modular addition per table
// entry, drains after each row, then sums the last row and doubles the sum.
// Throughput: one request at a time; ready is high only while idle, and a
// finished count waits in the output register without stalling new requests.
// Reset: async active low clears control state; the row store is not cleared.

module zigzag_permutation_counter (
    input  logic        clk,
    input  logic        rst_n,
    zz_len_if.sink      request,
    zz_count_if.source  result
);

    zz_pkg::zz_res_t          res;
    logic                     res_take;
    zz_pkg::zz_ram_req_t      ram_req;
    logic [zz_pkg::CNT_W-1:0] ram_rdata;
    logic [zz_pkg::CNT_W-1:0] add_a;
    logic [zz_pkg::CNT_W-1:0] add_b;
    logic [zz_pkg::CNT_W-1:0] add_sum;

    zz_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (request.valid),
        .req_length (request.length),
        .req_ready  (request.ready),
        .res        (res),
        .res_take   (res_take),
        .ram_req    (ram_req),
        .ram_rdata  (ram_rdata),
        .add_a      (add_a),
        .add_b      (add_b),
        .add_sum    (add_sum)
    );

    zz_modadd u_add (
        .a   (add_a),
        .b   (add_b),
        .sum (add_sum)
    );

    zz_ram #(
        .WIDTH (zz_pkg::CNT_W),
        .DEPTH (zz_pkg::MAX_LENGTH)
    ) u_row_store (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    zz_outreg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .res      (res),
        .res_take (res_take),
        .result   (result)
    );

    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        (request.valid && request.ready) |=> !request.ready)
        else $error("second request taken while busy");

endmodule
